// ===== src/kalman_angle_bias_filter_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the angle/bias filter unit
// Checks sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef KALMAN_ANGLE_BIAS_FILTER_UNIT_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define KABF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define KABF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/kabf_pkg.sv =====
// ---------------------------------------------------------------------------
// kabf_pkg
// Types, op codes and saturating fixed-point helpers for the filter unit.
// ---------------------------------------------------------------------------
`default_nettype none
package kabf_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int CW = 17;
  localparam int QW = DW + FB;

  localparam logic [1:0] REG_Q_ANGLE    = 2'd0;
  localparam logic [1:0] REG_Q_BIAS     = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

  localparam logic [CW-1:0] Q_ANGLE_RST    = CW'(66);
  localparam logic [CW-1:0] Q_BIAS_RST     = CW'(197);
  localparam logic [CW-1:0] MEAS_NOISE_RST = CW'(1966);

  typedef enum logic [4:0] {
    OP_RATE, OP_M_T_DT, OP_ANG1, OP_M_DT_C11, OP_T1, OP_T2, OP_T3, OP_M_DT_T,
    OP_C00, OP_M_QB_DT, OP_C11, OP_S, OP_DIV, OP_M_K0_Y, OP_ANG2, OP_M_K1_Y,
    OP_BIAS, OP_M_K0_C00, OP_N00, OP_M_K0_C01, OP_N01, OP_M_K1_C00, OP_N10,
    OP_M_K1_C01, OP_N11, OP_NOP
  } op_t;

  localparam logic [4:0] PROG_LAST = 5'(OP_N11);

  typedef struct packed {
    op_t  op;
    logic load_in;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic [CW-1:0] q_angle;
    logic [CW-1:0] q_bias;
    logic [CW-1:0] meas_noise;
  } cfg_t;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
    mag = a[DW-1] ? DW'(-a) : DW'(a);
  endfunction

  // clamp a magnitude to the signed range and apply the sign
  function automatic logic signed [DW-1:0] sat_mag(input logic [QW:0] m, input logic neg);
    logic [QW:0]   lim;
    logic [QW:0]   mm;
    logic [DW-1:0] r;
    lim = neg ? ((QW+1)'(1) << (DW-1)) : (((QW+1)'(1) << (DW-1)) - (QW+1)'(1));
    mm  = (m > lim) ? lim : m;
    r   = mm[DW-1:0];
    sat_mag = neg ? $signed(-r) : $signed(r);
  endfunction

  function automatic logic signed [DW-1:0] clamp(input logic signed [DW:0] s);
    if (s[DW] != s[DW-1]) begin
      clamp = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      clamp = s[DW-1:0];
    end
  endfunction

  function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    sadd = clamp({a[DW-1], a} + {b[DW-1], b});
  endfunction

  function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    ssub = clamp({a[DW-1], a} - {b[DW-1], b});
  endfunction

endpackage
`default_nettype wire

// ===== src/kabf_div.sv =====
// ---------------------------------------------------------------------------
// kabf_div
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
// ---------------------------------------------------------------------------
`default_nettype none
module kabf_div import kabf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [DW-1:0] num0,
  input  wire logic signed [DW-1:0] num1,
  input  wire logic signed [DW-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic signed [DW-1:0]      k0,
  output logic signed [DW-1:0]      k1
);

  localparam int CNTW = $clog2(QW + 1);

  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DW-1:0]     b_r;
  logic              dz_r;
  logic [1:0]        neg_r;
  logic [QW-1:0]     sh_r [2];
  logic [DW:0]       rem_r [2];
  logic [QW-1:0]     q_r [2];
  logic [DW:0]       rem_sh [2];
  logic              ge [2];
  logic [QW:0]       qf [2];
  logic signed [DW-1:0] k_r [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_sh[i] = {rem_r[i][DW-1:0], sh_r[i][QW-1]};
      ge[i]     = rem_sh[i] >= {1'b0, b_r};
      qf[i]     = {1'b0, q_r[i]} +
                  (QW+1)'({rem_r[i], 1'b0} >= {1'b0, 1'b0, b_r});
    end
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNTW'(1);
      if (cnt_r == CNTW'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      b_r      <= mag(den);
      dz_r     <= (den == '0);
      neg_r    <= {num1[DW-1] ^ den[DW-1], num0[DW-1] ^ den[DW-1]};
      sh_r[0]  <= {mag(num0), {FB{1'b0}}};
      sh_r[1]  <= {mag(num1), {FB{1'b0}}};
      for (int i = 0; i < 2; i++) begin
        rem_r[i] <= '0;
        q_r[i]   <= '0;
      end
    end else if (busy_r) begin
      for (int i = 0; i < 2; i++) begin
        sh_r[i]  <= {sh_r[i][QW-2:0], 1'b0};
        rem_r[i] <= ge[i] ? rem_sh[i] - {1'b0, b_r} : rem_sh[i];
        q_r[i]   <= {q_r[i][QW-2:0], ge[i]};
      end
    end
    // round on the final quotient and remainder
    if (done_r) begin
      for (int i = 0; i < 2; i++) begin
        k_r[i] <= dz_r ? '0 : sat_mag(qf[i], neg_r[i]);
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign k0   = k_r[0];
  assign k1   = k_r[1];

endmodule
`default_nettype wire

// ===== src/kabf_dp.sv =====
// ---------------------------------------------------------------------------
// kabf_dp
// Filter datapath: state registers, shared multiplier, adders, divider.
// ---------------------------------------------------------------------------
`default_nettype none
module kabf_dp import kabf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire cfg_t                 cfg,
  input  wire logic signed [DW-1:0] meas_angle,
  input  wire logic signed [DW-1:0] meas_rate,
  input  wire logic [CW-1:0]        time_step,
  output logic signed [DW-1:0]      angle_out
);

  logic signed [DW-1:0] z_r, w_r, t_r, d_r, s_r, y_r, out_r;
  logic [CW-1:0]        dt_r;
  logic signed [DW-1:0] ang_r, bias_r, c00_r, c01_r, c10_r, c11_r;
  logic [2*DW-1:0]      prod_r;
  logic                 pneg_r;
  logic signed [DW-1:0] ma, mb, dts, qas, qbs, rms, fm, k0, k1;
  logic [2*DW:0]        rnd;
  logic                 div_start, div_busy, div_done;

  assign dts = DW'(dt_r);
  assign qas = DW'(cfg.q_angle);
  assign qbs = DW'(cfg.q_bias);
  assign rms = DW'(cfg.meas_noise);

  always_comb begin
    case (cmd.op)
      OP_M_T_DT:   begin ma = t_r;  mb = dts;   end
      OP_M_DT_C11: begin ma = dts;  mb = c11_r; end
      OP_M_DT_T:   begin ma = dts;  mb = t_r;   end
      OP_M_QB_DT:  begin ma = qbs;  mb = dts;   end
      OP_M_K0_Y:   begin ma = k0;   mb = y_r;   end
      OP_M_K1_Y:   begin ma = k1;   mb = y_r;   end
      OP_M_K0_C00: begin ma = k0;   mb = c00_r; end
      OP_M_K0_C01: begin ma = k0;   mb = c01_r; end
      OP_M_K1_C00: begin ma = k1;   mb = c00_r; end
      OP_M_K1_C01: begin ma = k1;   mb = c01_r; end
      default:     begin ma = '0;   mb = '0;    end
    endcase
  end

  // rounded, scaled and saturated product of the previous multiply
  assign rnd = {1'b0, prod_r} + (2*DW+1)'(1 << (FB - 1));
  assign fm  = sat_mag(rnd[2*DW:FB], pneg_r);

  assign div_start = (cmd.op == OP_DIV);

  kabf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num0  (c00_r),
    .num1  (c10_r),
    .den   (s_r),
    .busy  (div_busy),
    .done  (div_done),
    .k0    (k0),
    .k1    (k1)
  );

  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r  <= '0;
      bias_r <= '0;
      c00_r  <= '0;
      c01_r  <= '0;
      c10_r  <= '0;
      c11_r  <= '0;
    end else begin
      case (cmd.op)
        OP_ANG1, OP_ANG2: ang_r <= sadd(ang_r, fm);
        OP_C00: begin
          c00_r <= sadd(c00_r, fm);
          c01_r <= ssub(c01_r, d_r);
          c10_r <= ssub(c10_r, d_r);
        end
        OP_C11:  c11_r  <= sadd(c11_r, fm);
        OP_BIAS: bias_r <= sadd(bias_r, fm);
        OP_N10:  c10_r  <= ssub(c10_r, fm);
        OP_N11: begin
          c11_r <= ssub(c11_r, fm);
          c00_r <= t_r;
          c01_r <= s_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= (2*DW)'(mag(ma)) * (2*DW)'(mag(mb));
    pneg_r <= ma[DW-1] ^ mb[DW-1];
    if (cmd.load_in) begin
      z_r  <= meas_angle;
      w_r  <= meas_rate;
      dt_r <= time_step;
    end
    if (cmd.load_out) begin
      out_r <= ang_r;
    end
    case (cmd.op)
      OP_RATE: t_r <= ssub(w_r, bias_r);
      OP_T1: begin
        t_r <= ssub(fm, c01_r);
        d_r <= fm;
      end
      OP_T2:  t_r <= ssub(t_r, c10_r);
      OP_T3:  t_r <= sadd(t_r, qas);
      OP_S: begin
        s_r <= sadd(c00_r, rms);
        y_r <= ssub(z_r, ang_r);
      end
      OP_N00: t_r <= ssub(c00_r, fm);
      OP_N01: s_r <= ssub(c01_r, fm);
      default: ;
    endcase
  end

  assign angle_out = out_r;

endmodule
`default_nettype wire

// ===== src/kabf_ctrl.sv =====
// ---------------------------------------------------------------------------
// kabf_ctrl
// Sequencer: steps the op program, waits on the divider, hands off results.
// ---------------------------------------------------------------------------
`default_nettype none
module kabf_ctrl import kabf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_FIN} state_t;

  state_t     state_r, state_nxt;
  logic [4:0] pc_r, pc_nxt;
  logic       ov_r, ov_nxt;
  logic       free;

  assign free = !ov_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    ov_nxt       = ov_r && out_stall;
    cmd.op       = OP_NOP;
    cmd.load_in  = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          pc_nxt      = '0;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.op = op_t'(pc_r);
        pc_nxt = pc_r + 5'd1;
        if (op_t'(pc_r) == OP_DIV) begin
          state_nxt = ST_DIV;
        end else if (pc_r == PROG_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_RUN;
        end
      end
      ST_FIN: begin
        if (free) begin
          cmd.load_out = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = ov_r;

endmodule
`default_nettype wire

// ===== src/kalman_angle_bias_filter_unit.sv =====
// ---------------------------------------------------------------------------
// kalman_angle_bias_filter_unit
// Two-state (angle, gyro bias) Kalman filter in signed Q16.16.
// ---------------------------------------------------------------------------
// Each accepted word (measured angle, gyro rate, time step) runs predict,
// gain and correct on the stored angle, bias and 2x2 covariance and yields
// one word with the new angle, saturated to 32 bits. For each word the
// sequencer runs 25 program steps through the single shared 32x32
// multiplier and adders, waiting partway on the 48-step bit-serial
// divider that forms both gains, then hands the result to the output
// register once it is free, and out_valid rises. No new word is
// accepted before that hand-off; in_stall stays high during that time;
// the finished word waits in the output register while the next word
// is processed. Registers q_angle, q_bias, meas_noise sit at byte
// addresses 0, 4 and 8 and should be written only while the unit is idle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "kalman_angle_bias_filter_unit_macros.svh"
module kalman_angle_bias_filter_unit import kabf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [DW-1:0] in_meas_angle,
  input  wire logic signed [DW-1:0] in_meas_rate,
  input  wire logic [CW-1:0]        in_time_step,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [DW-1:0]      out_angle_out
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.q_angle    <= Q_ANGLE_RST;
      cfg_r.q_bias     <= Q_BIAS_RST;
      cfg_r.meas_noise <= MEAS_NOISE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_Q_ANGLE:    cfg_r.q_angle    <= pwdata[CW-1:0];
        REG_Q_BIAS:     cfg_r.q_bias     <= pwdata[CW-1:0];
        REG_MEAS_NOISE: cfg_r.meas_noise <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_Q_ANGLE:    prdata = 32'(cfg_r.q_angle);
      REG_Q_BIAS:     prdata = 32'(cfg_r.q_bias);
      REG_MEAS_NOISE: prdata = 32'(cfg_r.meas_noise);
      default:        prdata = '0;
    endcase
  end

  kabf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kabf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg_r),
    .meas_angle (in_meas_angle),
    .meas_rate  (in_meas_rate),
    .time_step  (in_time_step),
    .angle_out  (out_angle_out)
  );

  `KABF_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
  `KABF_ASSERT_IMP(a_div_only_busy, sts.div_busy, in_stall, "divider runs while idle")
  `KABF_ASSERT_IMP(a_load_when_free, cmd.load_out, !out_valid || !out_stall, "output overwritten")

endmodule
`default_nettype wire
